// ===== rtl/arc_pkg.sv =====
// ----------------------------------------------------------------------------
// Arc evaluator package
// Shared constants, types and helper functions for the arc point evaluator.
// ----------------------------------------------------------------------------
package arc_pkg;

  localparam int CordicStagesDefault = 24;
  localparam int CordicMaxStages     = 32;
  localparam int AngleLatency        = 6;

  // Q.46 angle constants
  localparam logic signed [49:0] PiQ46    = 50'sd221069929750889;
  localparam logic signed [49:0] TwoPiQ46 = 50'sd442139859501778;
  // floor(2^65 / TwoPiQ46): turn count estimate from the top half of a product
  localparam logic signed [17:0] RecipTwoPi = 18'sd83443;
  // Q.30 angle constants
  localparam logic signed [33:0] PiQ30     = 34'sd3373259426;
  localparam logic signed [33:0] HalfPiQ30 = 34'sd1686629713;
  localparam logic signed [33:0] OneQ30    = 34'sd1073741824;
  localparam logic signed [33:0] InvGain   = 34'sd652032874;

  typedef enum logic [2:0] {
    REG_START_OFFSET  = 3'd0,
    REG_START_X       = 3'd1,
    REG_START_Y       = 3'd2,
    REG_START_HEADING = 3'd3,
    REG_ARC_CURVATURE = 3'd4
  } reg_idx_t;

  typedef enum logic [1:0] {
    FAULT_OK   = 2'd0,
    FAULT_ZERO = 2'd1,
    FAULT_SAT  = 2'd2
  } fault_t;

  typedef struct packed {
    logic               valid;
    logic signed [31:0] x0;
    logic signed [31:0] y0;
    logic signed [31:0] k;
    logic               zero_k;
  } side_t;

  function automatic logic signed [33:0] atan_entry(input int i);
    logic signed [33:0] r;
    case (i)
      0: r = 34'sh3243F6A8;  1: r = 34'sh1DAC6705;  2: r = 34'sh0FADBAFC;
      3: r = 34'sh07F56EA6;  4: r = 34'sh03FEAB76;  5: r = 34'sh01FFD55B;
      6: r = 34'sh00FFFAAA;  7: r = 34'sh007FFF55;  8: r = 34'sh003FFFEA;
      9: r = 34'sh001FFFFD; 10: r = 34'sh000FFFFF; 11: r = 34'sh0007FFFF;
      12: r = 34'sh0003FFFF; 13: r = 34'sh0001FFFF; 14: r = 34'sh0000FFFF;
      15: r = 34'sh00007FFF; 16: r = 34'sh00003FFF; 17: r = 34'sh00001FFF;
      18: r = 34'sh00000FFF; 19: r = 34'sh000007FF; 20: r = 34'sh000003FF;
      21: r = 34'sh000001FF; 22: r = 34'sh000000FF; 23: r = 34'sh0000007F;
      24: r = 34'sh0000003F; 25: r = 34'sh0000001F; 26: r = 34'sh0000000F;
      27: r = 34'sh00000008; 28: r = 34'sh00000004; 29: r = 34'sh00000002;
      30: r = 34'sh00000001;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic signed [33:0] clamp_unit(input logic signed [35:0] v);
    if (v > 36'(OneQ30)) return OneQ30;
    if (v < -36'(OneQ30)) return -OneQ30;
    return v[33:0];
  endfunction

endpackage

// ===== rtl/arc_cordic.sv =====
// ----------------------------------------------------------------------------
// Arc CORDIC
// Pipelined rotation CORDIC: one stage per register, quadrant fold at entry.
// ----------------------------------------------------------------------------
module arc_cordic #(
  parameter int STAGES = arc_pkg::CordicStagesDefault
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic signed [33:0]        in_angle,
  output logic                      out_valid,
  output logic signed [33:0]        out_cos,
  output logic signed [33:0]        out_sin
);
  import arc_pkg::*;

  localparam int N = (STAGES < CordicMaxStages) ? STAGES : CordicMaxStages;

  logic               v   [0:N];
  logic signed [35:0] xs  [0:N];
  logic signed [35:0] ys  [0:N];
  logic signed [35:0] zs  [0:N];
  logic               ng  [0:N];

  logic signed [35:0] z_fold;
  logic               neg_fold;

  always_comb begin
    z_fold   = 36'(in_angle);
    neg_fold = 1'b0;
    if (in_angle > HalfPiQ30) begin
      z_fold   = 36'(in_angle) - 36'(PiQ30);
      neg_fold = 1'b1;
    end else if (in_angle < -HalfPiQ30) begin
      z_fold   = 36'(in_angle) + 36'(PiQ30);
      neg_fold = 1'b1;
    end
  end

  assign v[0]  = in_valid;
  assign xs[0] = 36'(InvGain);
  assign ys[0] = '0;
  assign zs[0] = z_fold;
  assign ng[0] = neg_fold;

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic signed [35:0] xsh, ysh, at;
    assign xsh = xs[i] >>> i;
    assign ysh = ys[i] >>> i;
    assign at  = 36'(atan_entry(i));
    always_ff @(posedge clk) begin
      if (rst) begin
        v[i+1] <= 1'b0;
      end else if (en) begin
        v[i+1] <= v[i];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        ng[i+1] <= ng[i];
        if (!zs[i][35]) begin
          xs[i+1] <= xs[i] - ysh;
          ys[i+1] <= ys[i] + xsh;
          zs[i+1] <= zs[i] - at;
        end else begin
          xs[i+1] <= xs[i] + ysh;
          ys[i+1] <= ys[i] - xsh;
          zs[i+1] <= zs[i] + at;
        end
      end
    end
  end

  assign out_valid = v[N];
  assign out_cos   = clamp_unit(ng[N] ? -xs[N] : xs[N]);
  assign out_sin   = clamp_unit(ng[N] ? -ys[N] : ys[N]);
endmodule

// ===== rtl/arc_angle.sv =====
// ----------------------------------------------------------------------------
// Arc angle front end
// Computes wrapped Q.30 headings at s and at the arc start, over six stages.
// ----------------------------------------------------------------------------
module arc_angle (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  logic signed [31:0] road_offset,
  input  logic signed [31:0] s0,
  input  logic signed [31:0] h0,
  input  logic signed [31:0] k,
  output logic               out_valid,
  output logic signed [33:0] theta,
  output logic signed [33:0] theta0
);
  import arc_pkg::*;

  function automatic logic signed [33:0] round_q30(input logic signed [51:0] t);
    logic signed [51:0] q;
    q = (t + 52'sd32768) >>> 16;
    return q[33:0];
  endfunction

  // stage 1: difference
  logic               v1;
  logic signed [32:0] ds1;
  logic signed [49:0] h1;
  // stage 2: product, start heading folded into [-pi, pi)
  logic               v2;
  logic signed [64:0] p2;
  logic signed [49:0] h2;
  // stage 3: turn count estimate
  logic               v3;
  logic signed [50:0] qp3;
  logic signed [64:0] p3;
  logic signed [49:0] h3;
  // stage 4: remove whole turns, leaves (-2pi, 4pi)
  logic               v4;
  logic signed [17:0] qe;
  logic signed [65:0] r4;
  logic signed [49:0] h4;
  // stage 5: normalize to [0, 2pi) and add the start heading
  logic               v5;
  logic signed [65:0] rn;
  logic signed [51:0] t5;
  logic signed [49:0] h5;
  // stage 6: final wrap and round
  logic               v6;
  logic signed [51:0] tw;
  logic signed [33:0] th6, th06;

  assign qe = qp3[50:33];

  always_comb begin
    rn = r4;
    if (r4 < 0) begin
      rn = r4 + 66'(TwoPiQ46);
    end else if (r4 >= 66'(TwoPiQ46)) begin
      rn = r4 - 66'(TwoPiQ46);
    end
  end

  assign tw = (t5 >= 52'(PiQ46)) ? t5 - 52'(TwoPiQ46) : t5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0;
      v4 <= 1'b0; v5 <= 1'b0; v6 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid; v2 <= v1; v3 <= v2;
      v4 <= v3; v5 <= v4; v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ds1  <= 33'(road_offset) - 33'(s0);
      h1   <= {h0, 18'd0};
      p2   <= 65'(k) * 65'(ds1);
      if (h1 >= PiQ46) begin
        h2 <= h1 - TwoPiQ46;
      end else if (h1 < -PiQ46) begin
        h2 <= h1 + TwoPiQ46;
      end else begin
        h2 <= h1;
      end
      qp3  <= $signed(p2[64:32]) * RecipTwoPi;
      p3   <= p2;
      h3   <= h2;
      r4   <= 66'(p3) - 66'(qe) * 66'(TwoPiQ46);
      h4   <= h3;
      t5   <= $signed(rn[51:0]) + 52'(h4);
      h5   <= h4;
      th6  <= round_q30(tw);
      th06 <= round_q30(52'(h5));
    end
  end

  assign out_valid = v6;
  assign theta     = th6;
  assign theta0    = th06;
endmodule

// ===== rtl/arc_divider.sv =====
// ----------------------------------------------------------------------------
// Arc divider
// Pipelined restoring divider, one quotient bit per stage, truncating.
// ----------------------------------------------------------------------------
module arc_divider #(
  parameter int NW = 52,
  parameter int DW = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic signed [NW-1:0] num,
  input  logic signed [DW-1:0] den,
  output logic                 out_valid,
  output logic signed [NW-1:0] quo
);
  logic          v  [0:NW];
  logic [NW-1:0] q  [0:NW];
  logic [DW:0]   r  [0:NW];
  logic [DW:0]   d  [0:NW];
  logic          sg [0:NW];

  assign v[0]  = in_valid;
  assign q[0]  = num[NW-1] ? NW'(-num) : NW'(num);
  assign r[0]  = '0;
  assign d[0]  = den[DW-1] ? (DW+1)'(-(DW+1)'(den)) : (DW+1)'(den);
  assign sg[0] = num[NW-1] ^ den[DW-1];

  for (genvar i = 0; i < NW; i++) begin : g_bit
    logic [DW+1:0] tr;
    assign tr = {r[i], q[i][NW-1]};
    always_ff @(posedge clk) begin
      if (rst) begin
        v[i+1] <= 1'b0;
      end else if (en) begin
        v[i+1] <= v[i];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        d[i+1]  <= d[i];
        sg[i+1] <= sg[i];
        if (tr >= {1'b0, d[i]}) begin
          r[i+1] <= (DW+1)'(tr - {1'b0, d[i]});
          q[i+1] <= {q[i][NW-2:0], 1'b1};
        end else begin
          r[i+1] <= tr[DW:0];
          q[i+1] <= {q[i][NW-2:0], 1'b0};
        end
      end
    end
  end

  assign out_valid = v[NW];
  assign quo       = sg[NW] ? -$signed(q[NW]) : $signed(q[NW]);
endmodule

// ===== rtl/arc_point_and_tangent_eval.sv =====
// ----------------------------------------------------------------------------
// Arc point and tangent evaluator
// Requests pass through the angle, CORDIC, divider and output stages in order.
// Throughput: one request per cycle while the output is not stalled.
// The stage chain advances whenever the output register is free or taken.
// Reset clears all valid bits and the configuration registers.
// ----------------------------------------------------------------------------
module arc_point_and_tangent_eval #(
  parameter int CORDIC_STAGES = arc_pkg::CordicStagesDefault
) (
  input  logic               clk,
  input  logic               rst,
  // request channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] road_offset,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] point_x,
  output logic signed [31:0] point_y,
  output logic signed [31:0] tangent_x,
  output logic signed [31:0] tangent_y,
  output logic [1:0]         fault,
  // configuration
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import arc_pkg::*;

  localparam int NW   = 52;
  localparam int NCOR = (CORDIC_STAGES < CordicMaxStages) ? CORDIC_STAGES : CordicMaxStages;
  localparam int SIDE_LAT = AngleLatency + NCOR + 1 + NW;

  logic signed [31:0] s0, x0, y0, h0, k;
  logic en;

  // the whole chain moves as one; hold it while the output is stalled
  assign en        = !(out_valid && out_stall);
  assign in_stall  = !en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0 <= '0; x0 <= '0; y0 <= '0; h0 <= '0; k <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_START_OFFSET:  s0 <= cfg_data;
        REG_START_X:       x0 <= cfg_data;
        REG_START_Y:       y0 <= cfg_data;
        REG_START_HEADING: h0 <= cfg_data;
        REG_ARC_CURVATURE: k  <= cfg_data;
        default: ;
      endcase
    end
  end

  // angle front end
  logic               a_valid;
  logic signed [33:0] theta, theta0;
  arc_angle u_angle (
    .clk, .rst, .en,
    .in_valid (in_valid),
    .road_offset, .s0, .h0, .k,
    .out_valid(a_valid), .theta, .theta0
  );

  // two CORDIC pipes: heading at s and heading at start
  logic               c_valid, c0_valid;
  logic signed [33:0] ct, st, ch0, sh0;
  arc_cordic #(.STAGES(CORDIC_STAGES)) u_cor_t (
    .clk, .rst, .en, .in_valid(a_valid), .in_angle(theta),
    .out_valid(c_valid), .out_cos(ct), .out_sin(st)
  );
  arc_cordic #(.STAGES(CORDIC_STAGES)) u_cor_0 (
    .clk, .rst, .en, .in_valid(a_valid), .in_angle(theta0),
    .out_valid(c0_valid), .out_cos(ch0), .out_sin(sh0)
  );

  // register CORDIC results and form shifted numerators
  logic               n_valid;
  logic signed [NW-1:0] num_x, num_y;
  logic signed [33:0] ct_n, st_n, ch0_n, sh0_n;
  always_ff @(posedge clk) begin
    if (rst) begin
      n_valid <= 1'b0;
    end else if (en) begin
      n_valid <= c_valid & c0_valid;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      num_x <= NW'({NW'(35'(st) - 35'(sh0)), 16'd0});
      num_y <= NW'({NW'(35'(ch0) - 35'(ct)), 16'd0});
      ct_n  <= ct; st_n <= st; ch0_n <= ch0; sh0_n <= sh0;
    end
  end

  // sideband line carrying config snapshot alongside the item
  side_t side [0:SIDE_LAT];
  assign side[0] = '{valid: in_valid, x0: x0, y0: y0, k: k, zero_k: (k == 0)};
  for (genvar i = 0; i < SIDE_LAT; i++) begin : g_side
    always_ff @(posedge clk) begin
      if (rst) begin
        side[i+1].valid <= 1'b0;
      end else if (en) begin
        side[i+1].valid <= side[i].valid;
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        side[i+1].x0     <= side[i].x0;
        side[i+1].y0     <= side[i].y0;
        side[i+1].k      <= side[i].k;
        side[i+1].zero_k <= side[i].zero_k;
      end
    end
  end

  // trig delay line matching the divider
  logic signed [33:0] tcx [0:NW];
  logic signed [33:0] tsy [0:NW];
  logic signed [33:0] tcx0 [0:NW];
  logic signed [33:0] tsy0 [0:NW];
  assign tcx[0] = ct_n; assign tsy[0] = st_n;
  assign tcx0[0] = ch0_n; assign tsy0[0] = sh0_n;
  for (genvar i = 0; i < NW; i++) begin : g_trig
    always_ff @(posedge clk) begin
      if (en) begin
        tcx[i+1] <= tcx[i]; tsy[i+1] <= tsy[i];
        tcx0[i+1] <= tcx0[i]; tsy0[i+1] <= tsy0[i];
      end
    end
  end

  // division by curvature; divisor 1 stands in when k is zero
  logic signed [31:0]   kdiv;
  logic                 dx_valid, dy_valid;
  logic signed [NW-1:0] qx, qy;
  assign kdiv = (side[AngleLatency + NCOR + 1].k == 0) ? 32'sd1
                                                       : side[AngleLatency + NCOR + 1].k;
  arc_divider #(.NW(NW), .DW(32)) u_div_x (
    .clk, .rst, .en, .in_valid(n_valid), .num(num_x), .den(kdiv),
    .out_valid(dx_valid), .quo(qx)
  );
  arc_divider #(.NW(NW), .DW(32)) u_div_y (
    .clk, .rst, .en, .in_valid(n_valid), .num(num_y), .den(kdiv),
    .out_valid(dy_valid), .quo(qy)
  );

  // final add, saturate, pick special case
  side_t              sd;
  logic signed [NW:0] sx, sy;
  logic               satx, saty;
  assign sd   = side[SIDE_LAT];
  assign sx   = (NW+1)'(sd.x0) + (NW+1)'(qx);
  assign sy   = (NW+1)'(sd.y0) + (NW+1)'(qy);
  assign satx = (sx > (NW+1)'(32'sh7FFFFFFF)) || (sx < -(NW+1)'(33'sh080000000));
  assign saty = (sy > (NW+1)'(32'sh7FFFFFFF)) || (sy < -(NW+1)'(33'sh080000000));

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dx_valid & dy_valid & sd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (sd.zero_k) begin
        point_x   <= sd.x0;
        point_y   <= sd.y0;
        tangent_x <= 32'(tcx0[NW]);
        tangent_y <= 32'(tsy0[NW]);
        fault     <= FAULT_ZERO;
      end else begin
        point_x   <= satx ? (sx[NW] ? 32'sh80000000 : 32'sh7FFFFFFF) : sx[31:0];
        point_y   <= saty ? (sy[NW] ? 32'sh80000000 : 32'sh7FFFFFFF) : sy[31:0];
        tangent_x <= 32'(tcx[NW]);
        tangent_y <= 32'(tsy[NW]);
        fault     <= (satx || saty) ? FAULT_SAT : FAULT_OK;
      end
    end
  end
endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// Arc point and tangent evaluator testbench
// Drives road offsets through the evaluator under several arc setups. Checks
// every result against a fixed-point predictor of the heading wrap, the CORDIC
// and the divider, with random idling on both the request and result sides.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import arc_pkg::*;

  localparam int Stages = 24;
  localparam int LatencyCycles = AngleLatency + Stages + 1 + 52 + 1;
  localparam int CycleLimit = 600000;
  localparam int RandPhases = 9;
  localparam int ItemsPerPhase = 170;

  localparam longint ArcTan [32] = '{
    64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
    64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
    64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
    64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
    64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F, 64'h0000003F,
    64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002,
    64'h00000001, 64'h00000000};

  typedef struct {
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] tx;
    logic [31:0] ty;
    fault_t      flt;
  } arc_point_t;

  // Arc point scoreboard: holds its own copy of the arc registers and the
  // queue of points still owed by the block.
  class arc_scoreboard;
    logic signed [31:0] arc_reg [5];
    arc_point_t owed_points [$];
    int n_err;
    int n_checked;
    int n_zero;
    int n_sat;

    function new();
      foreach (arc_reg[i]) arc_reg[i] = '0;
      n_err = 0;
      n_checked = 0;
      n_zero = 0;
      n_sat = 0;
    endfunction

    function void set_reg(reg_idx_t idx, logic [31:0] v);
      arc_reg[idx] = v;
    endfunction

    // Reduce a Q.46 angle into [-pi, pi) and round it to Q.30.
    function longint wrap_angle(longint t);
      longint two_pi;
      longint pi46;
      two_pi = TwoPiQ46;
      pi46 = PiQ46;
      t = t % two_pi;
      if (t >= pi46) t -= two_pi;
      if (t < -pi46) t += two_pi;
      return (t + 64'sd32768) >>> 16;
    endfunction

    function longint clamp_q30(longint v);
      if (v > 64'sd1073741824) return 64'sd1073741824;
      if (v < -64'sd1073741824) return -64'sd1073741824;
      return v;
    endfunction

    // Rotation-mode CORDIC; fold into the right half plane first.
    function void rotate(longint z, output longint c, output longint s);
      longint x, y, nx;
      bit flip;
      x = InvGain;
      y = 0;
      flip = 0;
      if (z > longint'(HalfPiQ30)) begin
        z -= longint'(PiQ30);
        flip = 1;
      end else if (z < -longint'(HalfPiQ30)) begin
        z += longint'(PiQ30);
        flip = 1;
      end
      for (int i = 0; i < Stages; i++) begin
        if (z >= 0) begin
          nx = x - (y >>> i);
          y = y + (x >>> i);
          z -= ArcTan[i];
        end else begin
          nx = x + (y >>> i);
          y = y - (x >>> i);
          z += ArcTan[i];
        end
        x = nx;
      end
      if (flip) begin
        x = -x;
        y = -y;
      end
      c = clamp_q30(x);
      s = clamp_q30(y);
    endfunction

    function longint saturate(longint v, ref bit hit);
      if (v > 64'sd2147483647) begin
        hit = 1;
        return 64'sd2147483647;
      end
      if (v < -64'sd2147483648) begin
        hit = 1;
        return -64'sd2147483648;
      end
      return v;
    endfunction

    // Note an accepted offset and queue the point it must produce.
    function void note_request(logic signed [31:0] s);
      longint s0, x0, y0, h46, k, ch0, sh0, ct, st, px, py, d;
      bit hit;
      arc_point_t p;
      s0 = arc_reg[REG_START_OFFSET];
      x0 = arc_reg[REG_START_X];
      y0 = arc_reg[REG_START_Y];
      h46 = longint'(arc_reg[REG_START_HEADING]) * 64'sd262144;
      k = arc_reg[REG_ARC_CURVATURE];
      hit = 0;
      rotate(wrap_angle(h46), ch0, sh0);
      if (k == 0) begin
        px = x0;
        py = y0;
        ct = ch0;
        st = sh0;
        p.flt = FAULT_ZERO;
      end else begin
        d = (k * (longint'(s) - s0)) % longint'(TwoPiQ46);
        rotate(wrap_angle(d + h46), ct, st);
        px = saturate(x0 + ((st - sh0) * 64'sd65536) / k, hit);
        py = saturate(y0 + ((ch0 - ct) * 64'sd65536) / k, hit);
        p.flt = hit ? FAULT_SAT : FAULT_OK;
      end
      p.px = px[31:0];
      p.py = py[31:0];
      p.tx = ct[31:0];
      p.ty = st[31:0];
      owed_points = {owed_points, p};
    endfunction

    function void check_result(logic [31:0] px, logic [31:0] py, logic [31:0] tx,
                               logic [31:0] ty, logic [1:0] flt);
      arc_point_t p;
      if (owed_points.size() == 0) begin
        n_err++;
        if (n_err <= 10) $display("unexpected result x=%h y=%h", px, py);
        return;
      end
      p = owed_points.pop_front();
      n_checked++;
      if (p.flt == FAULT_ZERO) n_zero++;
      if (p.flt == FAULT_SAT) n_sat++;
      if (p.px !== px || p.py !== py || p.tx !== tx || p.ty !== ty || p.flt !== flt) begin
        n_err++;
        if (n_err <= 10)
          $display("mismatch: exp x=%h y=%h tx=%h ty=%h f=%0d  got x=%h y=%h tx=%h ty=%h f=%0d",
                   p.px, p.py, p.tx, p.ty, p.flt, px, py, tx, ty, flt);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [31:0] road_offset = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] point_x, point_y, tangent_x, tangent_y;
  logic [1:0] fault;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  arc_scoreboard sb = new();
  int gap_pct = 0;
  int stall_pct = 0;
  int cycles = 0;
  int n_req = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  arc_point_and_tangent_eval #(.CORDIC_STAGES(Stages)) u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .road_offset(road_offset),
    .out_valid(out_valid), .out_stall(out_stall),
    .point_x(point_x), .point_y(point_y),
    .tangent_x(tangent_x), .tangent_y(tangent_y), .fault(fault),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Watch both channels at the edge; values read here are the pre-edge ones.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        sb.note_request(road_offset);
        n_req++;
      end
      if (out_valid && !out_stall)
        sb.check_result(point_x, point_y, tangent_x, tangent_y, fault);
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Hard stop if the block hangs.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb NOT OK");
      $finish;
    end
  end

  task automatic write_reg(reg_idx_t idx, logic [31:0] v);
    cfg_index <= idx;
    cfg_data <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, v);
  endtask

  task automatic load_arc(logic [31:0] s0, logic [31:0] x0, logic [31:0] y0,
                          logic [31:0] h0, logic [31:0] k);
    write_reg(REG_START_OFFSET, s0);
    write_reg(REG_START_X, x0);
    write_reg(REG_START_Y, y0);
    write_reg(REG_START_HEADING, h0);
    write_reg(REG_ARC_CURVATURE, k);
    cfg_valid <= 1'b0;
  endtask

  // Offer one request; hold it until taken, idle cycle by cycle first.
  task automatic send_req(logic [31:0] v);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    road_offset <= v;
    do @(posedge clk); while (in_stall);
  endtask

  // Drop valid and wait until every owed point has come back, then let the
  // pipeline settle before any register write.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.owed_points.size() != 0) @(posedge clk);
    repeat (LatencyCycles + 10) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_curvature();
    case ($urandom_range(5))
      0: return '0;
      1: return $urandom;
      default: return $signed($urandom) >>> $urandom_range(20, 4);
    endcase
  endfunction

  // Offsets: mostly near the arc start so the arc stays on-scale, some anywhere.
  function automatic logic [31:0] rand_offset();
    if ($urandom_range(3) == 0) return $urandom;
    return sb.arc_reg[REG_START_OFFSET] + ($signed($urandom) >>> $urandom_range(12, 1));
  endfunction

  initial begin
    logic [31:0] edge_vals [6];
    edge_vals = '{32'h7FFFFFFF, 32'h80000000, 32'h0, 32'h1, 32'hFFFFFFFF, 32'h00010000};
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Zero curvature straight out of reset.
    foreach (edge_vals[i]) send_req(edge_vals[i]);
    drain();
    // Unit curvature: sweep the heading through all quadrants.
    load_arc(32'h0, 32'h0, 32'h0, 32'h0, 32'h40000000);
    for (int i = -4; i <= 4; i++) send_req(i * 32'sh0000C90F);
    drain();
    // Register extremes, likely saturating.
    load_arc(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h80000000);
    foreach (edge_vals[i]) send_req(edge_vals[i]);
    drain();
    // Tiny curvature drives the position far out.
    load_arc(32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h1);
    send_req(32'h7FFFFFFF);
    send_req(32'h00000000);
    drain();
    load_arc(32'h0, 32'h0, 32'h0, 32'h0, 32'h7FFFFFFF);
    send_req(32'h80000000);
    send_req(32'h7FFFFFFF);
    drain();

    for (int ph = 0; ph < RandPhases; ph++) begin
      if (ph < 3) begin
        gap_pct = 9;
        stall_pct = 81;
      end else if (ph < 6) begin
        gap_pct = 81;
        stall_pct = 9;
      end else begin
        gap_pct = 0;
        stall_pct = 0;
      end
      load_arc($urandom, $signed($urandom) >>> $urandom_range(8),
               $signed($urandom) >>> $urandom_range(8), $urandom, rand_curvature());
      for (int i = 0; i < ItemsPerPhase; i++) send_req(rand_offset());
      drain();
    end

    $display("%0d offsets sent, %0d points checked (%0d zero curvature, %0d saturated)",
             n_req, sb.n_checked, sb.n_zero, sb.n_sat);
    $display("%0d arc setups, %0d mismatches", 5 + RandPhases, sb.n_err);
    if (sb.n_err == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end
endmodule
